### design/pfq_pkg.sv
package pfq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic        io_flag;
    logic [31:0] wait_time;
    logic [31:0] run_time;
    logic [15:0] proc_id;
  } rec_t;

  typedef struct packed {
    logic              commit;
    logic              pop_hit;
    logic [DEPTH-1:0]  load;
    logic [DEPTH-1:0]  shift;
    status_t           status;
    logic [FILL_W-1:0] fill;
    logic              empty;
  } ctl_t;

endpackage

### design/process_fifo_with_remove_by_id_top.sv
// Bounded ready queue of DEPTH process records held in a row of cells, slot 0 at the head.
// Each input beat carries one operation (append, pop head, remove first matching id,
// query) and produces exactly one output beat with status, the popped record (zero unless
// a pop succeeded), the fill count and an empty flag. In the accept cycle every cell
// compares its id against the key in parallel; in the execute state, once the output
// register is free, the cells at and behind the hit shift one slot toward the head
// (or the tail cell is written) and the result register loads. A new beat is taken while
// the previous result still waits on the output; the block needs no clearing after reset.
module process_fifo_with_remove_by_id_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], proc_id[17:2], run_time[49:18], wait_time[81:50], io_flag[82], zero pad
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], out_id[17:2], out_run_time[49:18], out_wait_time[81:50],
  // out_io_flag[82], fill_count[87:83], is_empty[88], zero pad
  output logic [95:0] m_tdata
);
  import pfq_pkg::*;

  rec_t             in_rec;
  rec_t             rec_q;
  rec_t             cell_rec [DEPTH];
  logic [DEPTH-1:0] cell_match;
  ctl_t             ctl;

  status_t          status_q;
  rec_t             out_rec_q;
  logic [FILL_W-1:0] fill_q;
  logic             empty_q;

  assign in_rec.proc_id   = s_tdata[17:2];
  assign in_rec.run_time  = s_tdata[49:18];
  assign in_rec.wait_time = s_tdata[81:50];
  assign in_rec.io_flag   = s_tdata[82];

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rec_q <= in_rec;
    end
  end

  pfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .op_in    (op_t'(s_tdata[1:0])),
    .match    (cell_match),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = rec_q;
    end else begin : g_mid
      assign nbr = cell_rec[i+1];
    end
    pfq_cell u_cell (
      .clk     (clk),
      .load    (ctl.load[i]),
      .shift   (ctl.shift[i]),
      .new_rec (rec_q),
      .nbr_rec (nbr),
      .key     (in_rec.proc_id),
      .rec     (cell_rec[i]),
      .match   (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status_q  <= ctl.status;
      out_rec_q <= ctl.pop_hit ? cell_rec[0] : '0;
      fill_q    <= ctl.fill;
      empty_q   <= ctl.empty;
    end
  end

  assign m_tdata = {7'd0, empty_q, fill_q, out_rec_q.io_flag, out_rec_q.wait_time,
                    out_rec_q.run_time, out_rec_q.proc_id, status_q};

  // at most one tail slot is written per beat
  assert property (@(posedge clk) disable iff (rst) ctl.commit |-> $onehot0(ctl.load))
    else $error("more than one cell loaded");

  assert property (@(posedge clk) disable iff (rst) !((|ctl.load) && (|ctl.shift)))
    else $error("load and shift in the same cycle");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !ctl.shift[0] && ctl.load == '0) || ctl.commit)
    else $error("cells changed without a pending beat");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status_q == ST_EMPTY) |-> (empty_q && fill_q == '0))
    else $error("empty status with nonzero fill");

endmodule

### design/pfq_cell.sv
module pfq_cell (
  input  logic          clk,
  input  logic          load,
  input  logic          shift,
  input  pfq_pkg::rec_t new_rec,
  input  pfq_pkg::rec_t nbr_rec,
  input  logic [15:0]   key,
  output pfq_pkg::rec_t rec,
  output logic          match
);
  import pfq_pkg::*;

  // load wins; shift pulls the entry from the next cell toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      rec <= new_rec;
    end else if (shift) begin
      rec <= nbr_rec;
    end
  end

  assign match = (rec.proc_id == key);

endmodule

### design/pfq_ctrl.sv
module pfq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  pfq_pkg::op_t              op_in,
  input  logic [pfq_pkg::DEPTH-1:0] match,
  output pfq_pkg::ctl_t             ctl
);
  import pfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [DEPTH-1:0]  match_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DEPTH-1:0]  occ;
  logic [DEPTH-1:0]  sel;
  logic [DEPTH-1:0]  tail_sel;
  logic              found;
  logic              full;
  logic              empty_now;
  logic              commit;
  logic              accept;
  status_t           status_next;
  logic              do_load;
  logic              do_shift;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]      = (CNT_W'(i) < count);
      tail_sel[i] = (CNT_W'(i) == count);
    end
  end

  assign full      = (count == CNT_W'(DEPTH));
  assign empty_now = (count == '0);
  assign sel       = (op_q == OP_POP) ? ({{(DEPTH-1){1'b0}}, 1'b1} & occ) : (match_q & occ);
  assign found     = |sel;

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    do_load     = 1'b0;
    do_shift    = 1'b0;
    unique case (op_q)
      OP_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          do_load    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP, OP_REMOVE: begin
        if (empty_now) begin
          status_next = ST_EMPTY;
        end else if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          do_shift   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_QUERY: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // sel | -sel sets every bit from the first hit toward the tail
  always_comb begin
    ctl.commit  = commit;
    ctl.pop_hit = do_shift && (op_q == OP_POP);
    ctl.load    = (commit && do_load) ? tail_sel : '0;
    ctl.shift   = (commit && do_shift) ? (sel | ((~sel) + DEPTH'(1))) : '0;
    ctl.status  = status_next;
    ctl.fill    = FILL_W'(count_next);
    ctl.empty   = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_in;
      match_q <= match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import pfq_pkg::*;

  typedef struct {
    op_t  op;
    rec_t rec;
    bit   hold;   // wait for all outstanding results before presenting this beat
  } job_t;

  typedef struct packed {
    status_t           status;
    rec_t              rec;
    logic [FILL_W-1:0] fill;
    logic              empty;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;

  job_t     job_queue[$];
  outcome_t due_results[$];
  rec_t     ready_list[$];
  job_t     on_bus;
  int       sent_count = 0;
  int       got_count = 0;
  int       errors = 0;

  process_fifo_with_remove_by_id_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicts one result and updates the ready list the same way the block must.
  function automatic outcome_t apply_to_ready_list(job_t j);
    outcome_t r;
    int hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (j.op)
      OP_APPEND: begin
        if (ready_list.size() >= DEPTH) r.status = ST_FULL;
        else ready_list.push_back(j.rec);
      end
      OP_POP: begin
        if (ready_list.size() == 0) r.status = ST_EMPTY;
        else r.rec = ready_list.pop_front();
      end
      OP_REMOVE: begin
        if (ready_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int k = 0; k < ready_list.size(); k++)
            if (hit < 0 && ready_list[k].proc_id == j.rec.proc_id) hit = k;
          if (hit >= 0) ready_list.delete(hit);
          else r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(ready_list.size());
    r.empty = (ready_list.size() == 0);
    return r;
  endfunction

  function automatic void add_job(op_t op, logic [15:0] id, logic [31:0] rt,
                                  logic [31:0] wt, logic io, bit hold);
    job_t j;
    j.op = op;
    j.rec.proc_id = id;
    j.rec.run_time = rt;
    j.rec.wait_time = wt;
    j.rec.io_flag = io;
    j.hold = hold;
    job_queue.push_back(j);
  endfunction

  function automatic void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  // Sender: one beat on the bus at a time, random gaps outside the quiet window.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(apply_to_ready_list(on_bus));
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (job_queue.size() > 0 && !(job_queue[0].hold && due_results.size() > 0) &&
            ((sent_count >= 300 && sent_count < 400) || $urandom_range(99) >= 29)) begin
          on_bus = job_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {5'b0, on_bus.rec, on_bus.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_count++;
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          compare("status", want.status, m_tdata[1:0]);
          compare("out_id", want.rec.proc_id, m_tdata[17:2]);
          compare("out_run_time", want.rec.run_time, m_tdata[49:18]);
          compare("out_wait_time", want.rec.wait_time, m_tdata[81:50]);
          compare("out_io_flag", want.rec.io_flag, m_tdata[82]);
          compare("fill_count", want.fill, m_tdata[87:83]);
          compare("is_empty", want.empty, m_tdata[88]);
        end
      end
      m_tready <= (got_count >= 300 && got_count < 400) || ($urandom_range(99) >= 29);
    end
  end

  initial begin
    int mode;
    int r;
    op_t op;
    logic [15:0] id;

    // empty queue corner cases
    add_job(OP_QUERY, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0);
    add_job(OP_POP, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    add_job(OP_REMOVE, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0);
    // field extremes and a duplicate id
    add_job(OP_APPEND, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0);
    add_job(OP_APPEND, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    add_job(OP_APPEND, 16'h0000, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b0);
    add_job(OP_REMOVE, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0);   // takes the head copy
    add_job(OP_REMOVE, 16'h1234, 32'h0, 32'h0, 1'b0, 1'b0);   // no match
    add_job(OP_POP, 16'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    // fill up, overflow, then remove from the middle and the tail
    for (int k = 0; k < DEPTH - 1; k++)
      add_job(OP_APPEND, 16'(100 + k), $urandom, $urandom, 1'($urandom), 1'b0);
    add_job(OP_APPEND, 16'h0007, 32'h1, 32'h2, 1'b1, 1'b0);
    add_job(OP_REMOVE, 16'd107, 32'h0, 32'h0, 1'b0, 1'b0);
    add_job(OP_REMOVE, 16'd114, 32'h0, 32'h0, 1'b0, 1'b0);
    add_job(OP_POP, 16'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    add_job(OP_QUERY, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);

    // random phases lean toward filling, draining or a mix
    mode = 0;
    for (int n = 0; n < 550; n++) begin
      if (n % 60 == 0) mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0: begin
          if (r < 65) op = OP_APPEND;
          else if (r < 80) op = OP_POP;
          else if (r < 92) op = OP_REMOVE;
          else op = OP_QUERY;
        end
        1: begin
          if (r < 20) op = OP_APPEND;
          else if (r < 55) op = OP_POP;
          else if (r < 90) op = OP_REMOVE;
          else op = OP_QUERY;
        end
        default: begin
          if (r < 40) op = OP_APPEND;
          else if (r < 65) op = OP_POP;
          else if (r < 88) op = OP_REMOVE;
          else op = OP_QUERY;
        end
      endcase
      // small id pool so removes hit and duplicates show up
      id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      add_job(op, id, $urandom, $urandom, 1'($urandom), (n % 150) == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (job_queue.size() > 0 || s_tvalid || due_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
design/pfq_pkg.sv
design/pfq_cell.sv
design/pfq_ctrl.sv
design/process_fifo_with_remove_by_id_top.sv
bench/tb_top.sv
